@@ rtl/core/rss_pkg.sv @@
// Package for the rotor substitution stepper: letter types, opcodes, register
// indexes and mod-26 helper functions. No dependencies.
package rss_pkg;

  localparam int Letters = 26;

  typedef logic [4:0] letter_t;

  typedef enum logic [2:0] {
    OP_FORWARD   = 3'd0,
    OP_BACKWARD  = 3'd1,
    OP_STEP_FWD  = 3'd2,
    OP_STEP_BACK = 3'd3,
    OP_SET_POS   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    REG_WIRING_FIRST  = 3'd0,
    REG_WIRING_MIDDLE = 3'd1,
    REG_WIRING_LAST   = 3'd2,
    REG_RING_SETTING  = 3'd3,
    REG_NOTCH_LETTER  = 3'd4
  } cfg_reg_t;

  // Configuration as seen by the datapath; all letters already reduced mod 26.
  typedef struct packed {
    logic [Letters-1:0][4:0] wire_table;
    letter_t                 ring_shift;
    letter_t                 adj_notch;
  } rss_cfg_t;

  function automatic letter_t mod26_5(input logic [4:0] v);
    logic [4:0] r;
    r = (v >= 5'd26) ? (v - 5'd26) : v;
    return r;
  endfunction

  // Reciprocal multiply: floor(v * 79 / 2048) equals floor(v / 26) for v < 256.
  function automatic letter_t mod26_8(input logic [7:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [7:0]  r;
    p = {7'b0, v} * 15'd79;
    q = p[14:11];
    r = v - ({4'b0, q} * 8'd26);
    return r[4:0];
  endfunction

  function automatic letter_t add_mod26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'd26) s = s - 6'd26;
    return s[4:0];
  endfunction

  function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + 6'd26 - {1'b0, b};
    if (s >= 6'd26) s = s - 6'd26;
    return s[4:0];
  endfunction

endpackage

@@ rtl/core/rss_cfg.sv @@
// Configuration registers of the rotor: wiring table, ring setting and notch.
// Depends on rss_pkg.
module rss_cfg
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  output rss_cfg_t    cfg
);

  logic [Letters-1:0][4:0] wire_table;
  letter_t                 ring;
  letter_t                 notch;
  logic                    wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Letter codes above 25 are folded as they are written.
  always_ff @(posedge clk) begin
    if (rst) begin
      wire_table <= '0;
      ring       <= 5'd1;
      notch      <= 5'd0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_WIRING_FIRST: begin
          for (int i = 0; i < 12; i++) wire_table[i] <= mod26_5(cfg_data[5*i +: 5]);
        end
        REG_WIRING_MIDDLE: begin
          for (int i = 0; i < 12; i++) wire_table[12+i] <= mod26_5(cfg_data[5*i +: 5]);
        end
        REG_WIRING_LAST: begin
          wire_table[24] <= mod26_5(cfg_data[4:0]);
          wire_table[25] <= mod26_5(cfg_data[9:5]);
        end
        REG_RING_SETTING: ring  <= mod26_5(cfg_data[4:0]);
        REG_NOTCH_LETTER: notch <= mod26_5(cfg_data[4:0]);
        default: ;
      endcase
    end
  end

  // The effective offset is position plus (1 - ring) mod 26.
  assign cfg.wire_table = wire_table;
  assign cfg.ring_shift = sub_mod26(5'd1, ring);
  assign cfg.adj_notch  = sub_mod26(notch, ring);

endmodule

@@ rtl/core/rss_core.sv @@
// Rotor datapath: input register, position register, one pass of substitution
// or stepping logic, and the result register. Depends on rss_pkg.
module rss_core
  import rss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rss_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [4:0] signal_in,
  input  logic [7:0] amount,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] signal_out,
  output logic [4:0] position_now,
  output logic [4:0] adjusted_notch
);

  logic       a_valid;
  logic [2:0] a_op;
  letter_t    a_sig;
  letter_t    a_amt;
  letter_t    position;
  letter_t    position_next;
  letter_t    result;
  letter_t    eff;
  letter_t    idx;
  letter_t    inv;
  logic       adv_out;
  logic       adv_in;

  assign adv_out  = ~out_valid | ~out_stall;
  assign adv_in   = ~a_valid | adv_out;
  assign in_stall = ~adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      position  <= '0;
    end else begin
      if (adv_in) a_valid <= in_valid;
      if (adv_out) out_valid <= a_valid;
      if (adv_out && a_valid) position <= position_next;
    end
  end

  // Operands are reduced mod 26 on the way into the input register.
  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      a_op  <= opcode;
      a_sig <= mod26_5(signal_in);
      a_amt <= mod26_8(amount);
    end
  end

  assign eff = add_mod26(position, cfg.ring_shift);
  assign idx = add_mod26(a_sig, eff);

  // Inverse wiring: lowest input whose letter matches, else the letter itself.
  always_comb begin
    inv = idx;
    for (int i = Letters - 1; i >= 0; i--) begin
      if (cfg.wire_table[i] == idx) inv = 5'(i);
    end
  end

  always_comb begin
    result        = '0;
    position_next = position;
    unique case (a_op)
      OP_FORWARD:   result        = sub_mod26(cfg.wire_table[idx], eff);
      OP_BACKWARD:  result        = sub_mod26(inv, eff);
      OP_STEP_FWD:  position_next = add_mod26(position, a_amt);
      OP_STEP_BACK: position_next = sub_mod26(position, a_amt);
      OP_SET_POS:   position_next = a_sig;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out && a_valid) begin
      signal_out     <= result;
      position_now   <= position_next;
      adjusted_notch <= cfg.adj_notch;
    end
  end

endmodule

@@ rtl/core/rotor_substitution_stepper.sv @@
// Rotor substitution stepper: one cipher rotor over 26 letters.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the output is not stalled.
// The position feedback is a single mod-26 add, subtract or load in the one stage.
// Synchronous reset clears the position to A, ring to 1, notch and wiring to 0.
// Depends on rss_pkg, rss_cfg and rss_core.
module rotor_substitution_stepper
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [4:0]  signal_in,
  input  logic [7:0]  amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  signal_out,
  output logic [4:0]  position_now,
  output logic [4:0]  adjusted_notch
);

  rss_cfg_t cfg;

  rss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rss_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .signal_in      (signal_in),
    .amount         (amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .signal_out     (signal_out),
    .position_now   (position_now),
    .adjusted_notch (adjusted_notch)
  );

endmodule

@@ rtl/core/rss_checker.sv @@
// Port-level checker for the rotor substitution stepper, bound to the top level.
// Depends on the top level's ports only.
module rss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  signal_out,
  input logic [4:0]  position_now,
  input logic [4:0]  adjusted_notch
);

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Every reported letter is a real letter.
  a_letters: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (signal_out < 5'd26) && (position_now < 5'd26) &&
                  (adjusted_notch < 5'd26))
    else $error("result letter out of range");

  // The input side is only held back when both stages are full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side can move");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(signal_out) &&
                               $stable(position_now) && $stable(adjusted_notch))
    else $error("stalled result changed");

endmodule

bind rotor_substitution_stepper rss_checker u_rss_checker (.*);

@@ tb/sv/rotor_result_checker.sv @@
// Checker for the rotor substitution stepper: mirrors the configuration writes,
// predicts each result from its own copy of the rotor, and compares in order.
// Depends on rss_pkg for the opcode and register index names.
module rotor_result_checker
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [4:0]  signal_in,
  input  logic [7:0]  amount,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  signal_out,
  input  logic [4:0]  position_now,
  input  logic [4:0]  adjusted_notch,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    letter_t cipher;
    letter_t position;
    letter_t notch;
  } rotor_result_t;

  logic [59:0] cfg_wiring_first;
  logic [59:0] cfg_wiring_middle;
  logic [9:0]  cfg_wiring_last;
  logic [4:0]  cfg_ring;
  logic [4:0]  cfg_notch;
  letter_t     rotor_pos;

  rotor_result_t cipher_results_q[$];

  // Wiring entry for one input letter, reduced to the alphabet.
  function automatic int wire_letter(input int idx);
    logic [59:0] w;
    if (idx < 12) begin
      w = cfg_wiring_first >> (5 * idx);
    end else if (idx < 24) begin
      w = cfg_wiring_middle >> (5 * (idx - 12));
    end else begin
      w = {50'b0, cfg_wiring_last} >> (5 * (idx - 24));
    end
    return int'(w[4:0]) % Letters;
  endfunction

  // Lowest input whose wiring hits the letter; the letter itself if none does.
  function automatic int wire_inverse(input int target);
    for (int i = 0; i < Letters; i++) begin
      if (wire_letter(i) == target) return i;
    end
    return target;
  endfunction

  function automatic rotor_result_t predict_rotor_item(input logic [2:0] op,
                                                       input logic [4:0] sig_raw,
                                                       input logic [7:0] amt_raw);
    int sig, amt, ring, eff, res;
    rotor_result_t r;
    sig  = int'(sig_raw) % Letters;
    amt  = int'(amt_raw) % Letters;
    ring = int'(cfg_ring) % Letters;
    eff  = (int'(rotor_pos) + Letters + 1 - ring) % Letters;
    res  = 0;
    case (op)
      OP_FORWARD:   res = (wire_letter((sig + eff) % Letters) + Letters - eff) % Letters;
      OP_BACKWARD:  res = (wire_inverse((sig + eff) % Letters) + Letters - eff) % Letters;
      OP_STEP_FWD:  rotor_pos = letter_t'((int'(rotor_pos) + amt) % Letters);
      OP_STEP_BACK: rotor_pos = letter_t'((int'(rotor_pos) + Letters - amt) % Letters);
      OP_SET_POS:   rotor_pos = letter_t'(sig);
      default: ;
    endcase
    r.cipher   = letter_t'(res);
    r.position = rotor_pos;
    r.notch    = letter_t'((int'(cfg_notch) % Letters + Letters - ring) % Letters);
    return r;
  endfunction

  task automatic report_field(input string name, input letter_t want, input letter_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rotor_result_t want;
    if (rst) begin
      cfg_wiring_first  = '0;
      cfg_wiring_middle = '0;
      cfg_wiring_last   = '0;
      cfg_ring          = 5'd1;
      cfg_notch         = '0;
      rotor_pos         = '0;
      fail_count        = 0;
      cipher_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_results_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0d/%0d/%0d", $time,
                   signal_out, position_now, adjusted_notch);
          fail_count++;
        end else begin
          want = cipher_results_q.pop_front();
          report_field("signal_out", want.cipher, signal_out);
          report_field("position_now", want.position, position_now);
          report_field("adjusted_notch", want.notch, adjusted_notch);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIRING_FIRST:  cfg_wiring_first  = cfg_data;
          REG_WIRING_MIDDLE: cfg_wiring_middle = cfg_data;
          REG_WIRING_LAST:   cfg_wiring_last   = cfg_data[9:0];
          REG_RING_SETTING:  cfg_ring          = cfg_data[4:0];
          REG_NOTCH_LETTER:  cfg_notch         = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cipher_results_q.push_back(predict_rotor_item(opcode, signal_in, amount));
      end
    end
    pending_count = cipher_results_q.size();
  end

endmodule

@@ tb/sv/rotor_substitution_stepper_test.sv @@
// Top of the rotor substitution stepper test: clock, reset, configuration,
// request stimulus and output stalls, with rotor_result_checker beside the block.
// Depends on rss_pkg, rotor_substitution_stepper and rotor_result_checker.
module rotor_substitution_stepper_test;
  import rss_pkg::*;

  localparam int          NumPhases   = 10;
  localparam int          PhaseItems  = 185;
  localparam byte         AsciiA      = 8'd65;
  localparam logic [2:0]  OpUnusedLo  = 3'd5;
  localparam logic [2:0]  OpUnusedHi  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_WIRING_FIRST;
  logic [59:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = OP_FORWARD;
  logic [4:0]  signal_in = '0;
  logic [7:0]  amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  signal_out;
  logic [4:0]  position_now;
  logic [4:0]  adjusted_notch;
  int          fail_count;
  int          pending_count;
  bit          steady = 1'b0;

  always #2 clk = ~clk;

  rotor_substitution_stepper u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .signal_in(signal_in), .amount(amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .signal_out(signal_out), .position_now(position_now),
    .adjusted_notch(adjusted_notch)
  );

  rotor_result_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .signal_in(signal_in), .amount(amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .signal_out(signal_out), .position_now(position_now),
    .adjusted_notch(adjusted_notch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [4:0] sig,
                              input logic [7:0] amt);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    opcode    = op;
    signal_in = sig;
    amount    = amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drains the block so that the registers may be rewritten.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [59:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_rotor(input letter_t letters [26], input logic [4:0] ring,
                            input logic [4:0] notch);
    logic [59:0] first_w, middle_w;
    logic [9:0]  last_w;
    for (int i = 0; i < 12; i++) begin
      first_w[5*i +: 5]  = letters[i];
      middle_w[5*i +: 5] = letters[12+i];
    end
    last_w = {letters[25], letters[24]};
    write_reg(REG_WIRING_FIRST, first_w);
    write_reg(REG_WIRING_MIDDLE, middle_w);
    write_reg(REG_WIRING_LAST, {50'b0, last_w});
    write_reg(REG_RING_SETTING, {55'b0, ring});
    write_reg(REG_NOTCH_LETTER, {55'b0, notch});
    cfg_valid = 1'b0;
  endtask

  task automatic shuffle_letters(output letter_t letters [26]);
    int j;
    letter_t t;
    for (int i = 0; i < 26; i++) letters[i] = letter_t'(i);
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = letters[i];
      letters[i] = letters[j];
      letters[j] = t;
    end
  endtask

  task automatic random_request();
    int r;
    logic [2:0] op;
    logic [4:0] sig;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_FORWARD;
    else if (r < 60) op = OP_BACKWARD;
    else if (r < 72) op = OP_STEP_FWD;
    else if (r < 84) op = OP_STEP_BACK;
    else if (r < 94) op = OP_SET_POS;
    else             op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    // Letter codes past Z are rare but must reach the block.
    sig = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
                                       : 5'($urandom_range(0, 25));
    send_request(op, sig, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    string   rotor_i;
    letter_t letters [26];
    logic [4:0] ring, notch;
    rotor_i = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset wiring is all A, so the backward pass mostly finds no match.
    send_request(OP_FORWARD, 5'd0, 8'd0);
    send_request(OP_BACKWARD, 5'd0, 8'd0);
    send_request(OP_BACKWARD, 5'd7, 8'd0);
    settle();

    for (int i = 0; i < 26; i++) letters[i] = letter_t'(rotor_i.getc(i) - AsciiA);
    load_rotor(letters, 5'd1, 5'd16);
    send_request(OP_FORWARD, 5'd0, 8'd0);
    send_request(OP_FORWARD, 5'd25, 8'd255);
    send_request(OP_BACKWARD, 5'd0, 8'd0);
    send_request(OP_BACKWARD, 5'd25, 8'd0);
    send_request(OP_STEP_FWD, 5'd0, 8'd255);
    send_request(OP_FORWARD, 5'd31, 8'd0);
    send_request(OP_BACKWARD, 5'd26, 8'd0);
    send_request(OP_STEP_BACK, 5'd0, 8'd1);
    send_request(OP_STEP_BACK, 5'd31, 8'd255);
    send_request(OP_STEP_FWD, 5'd0, 8'd0);
    send_request(OP_STEP_FWD, 5'd0, 8'd26);
    send_request(OP_SET_POS, 5'd25, 8'd0);
    send_request(OP_FORWARD, 5'd12, 8'd0);
    send_request(OP_SET_POS, 5'd31, 8'd0);
    for (int op = OpUnusedLo; op <= OpUnusedHi; op++) begin
      send_request(op[2:0], 5'd31, 8'd255);
    end
    send_request(OP_SET_POS, 5'd0, 8'd0);
    send_request(OP_STEP_BACK, 5'd0, 8'd0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          for (int i = 0; i < 26; i++) letters[i] = letter_t'(rotor_i.getc(i) - AsciiA);
          ring  = 5'd26;
          notch = 5'd25;
        end
        1: begin
          shuffle_letters(letters);
          ring  = 5'd0;
          notch = 5'd31;
        end
        2: begin
          for (int i = 0; i < 26; i++) letters[i] = 5'd31;
          ring  = 5'd31;
          notch = 5'd26;
        end
        3: begin
          for (int i = 0; i < 26; i++) letters[i] = letter_t'(i);
          ring  = 5'd1;
          notch = 5'd0;
        end
        default: begin
          // Some phases use wiring that is not a permutation at all.
          if (ph == 4 || $urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 26; i++) letters[i] = letter_t'($urandom_range(0, 31));
          end else begin
            shuffle_letters(letters);
          end
          ring  = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 26));
          notch = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(0, 25));
        end
      endcase
      load_rotor(letters, ring, notch);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        random_request();
      end
      steady = 1'b0;
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: random stalls, plus long hold-offs that back the block up.
  initial begin
    int cycle_count, hold_left, stall_left, free_left;
    cycle_count = 0;
    hold_left   = 0;
    stall_left  = 0;
    free_left   = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count == 1500 || cycle_count == 4000) hold_left = 200;
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall = 1'b0;
        free_left--;
      end else begin
        out_stall  = 1'b0;
        free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 100) : pick_gap();
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rss_pkg.sv
rtl/core/rss_cfg.sv
rtl/core/rss_core.sv
rtl/core/rotor_substitution_stepper.sv
rtl/core/rss_checker.sv
tb/sv/rotor_result_checker.sv
tb/sv/rotor_substitution_stepper_test.sv
